// ----- hw/rtl/sfcpq_pkg.sv -----
package sfcpq_pkg;

  // Field widths
  localparam int TAG_W   = 16;
  localparam int AGE_W   = 7;
  localparam int CLS_W   = 2;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  // Defaults
  localparam int DEF_CAPACITY = 16;
  localparam logic [AGE_W-1:0] THRESH_RESET = 7'd60;

  // Opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  // Class codes, lower is better (class 1 maps to code 0)
  localparam logic [CLS_W-1:0] CLS_BOTH = 2'd0;
  localparam logic [CLS_W-1:0] CLS_COND = 2'd1;
  localparam logic [CLS_W-1:0] CLS_OLD  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NONE = 2'd3;

  // One queued entry
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
    logic             cond;
    logic [CLS_W-1:0] cls;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } ctrl_t;

  function automatic logic [CLS_W-1:0] class_of(input logic [AGE_W-1:0] age,
                                                input logic             cond,
                                                input logic [AGE_W-1:0] thresh);
    logic old;
    old = (age >= thresh);
    if (old && cond)  class_of = CLS_BOTH;
    else if (cond)    class_of = CLS_COND;
    else if (old)     class_of = CLS_OLD;
    else              class_of = CLS_NONE;
  endfunction

endpackage

// ----- hw/rtl/sfcpq_cell.sv -----
module sfcpq_cell (
  input  logic              clk,
  input  sfcpq_pkg::ctrl_t  ctrl,
  input  logic              occ,       // this slot holds a live entry
  input  sfcpq_pkg::entry_t left_ent,
  input  logic              left_le,   // left neighbor stays in place on insert
  input  sfcpq_pkg::entry_t right_ent,
  output sfcpq_pkg::entry_t ent,
  output logic              le
);

  sfcpq_pkg::entry_t ent_r;
  sfcpq_pkg::entry_t ent_nxt;

  // Live entry of equal or better class keeps its place on insert
  assign le  = occ && (ent_r.cls <= ctrl.ent.cls);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.deq) begin
      ent_nxt = right_ent;
    end else if (ctrl.enq) begin
      if (le) begin
        ent_nxt = ent_r;
      end else if (left_le) begin
        ent_nxt = ctrl.ent;
      end else begin
        ent_nxt = left_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- hw/rtl/stable_four_class_priority_queue.sv -----
// The result is valid in the cycle after an input is accepted.
// Throughput: one item per cycle while the result side takes each result;
// the cell row inserts or removes an entry in a single shift.
// Reset: entry count zero, age threshold 60, no result pending.
// Entry contents are not cleared; only slots below the count are read.
module stable_four_class_priority_queue #(
  parameter int CAPACITY = sfcpq_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sfcpq_pkg::AGE_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [sfcpq_pkg::TAG_W-1:0]   in_tag,
  input  logic [sfcpq_pkg::AGE_W-1:0]   in_age,
  input  logic                          in_condition,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfcpq_pkg::STAT_W-1:0]  out_status,
  output logic [sfcpq_pkg::TAG_W-1:0]   out_tag,
  output logic [sfcpq_pkg::AGE_W-1:0]   out_age,
  output logic                          out_condition,
  output logic [sfcpq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [sfcpq_pkg::AGE_W-1:0] thresh_r;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic [sfcpq_pkg::STAT_W-1:0] status_r, status_nxt;
  sfcpq_pkg::entry_t           head_r, head_nxt;
  logic [31:0]                 cnt_ext;

  logic                        in_fire, full, empty;
  sfcpq_pkg::ctrl_t            ctrl;
  sfcpq_pkg::entry_t           cell_ent [CAPACITY];
  logic [CAPACITY-1:0]         cell_le;

  assign in_fire = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign full    = (cnt_r == CAP_C);
  assign empty   = (cnt_r == '0);

  // Command to the cell row
  always_comb begin
    ctrl.enq      = in_fire && (in_opcode == sfcpq_pkg::OP_ENQ) && !full;
    ctrl.deq      = in_fire && (in_opcode == sfcpq_pkg::OP_DEQ) && !empty;
    ctrl.ent.tag  = in_tag;
    ctrl.ent.age  = in_age;
    ctrl.ent.cond = in_condition;
    ctrl.ent.cls  = sfcpq_pkg::class_of(in_age, in_condition, thresh_r);
  end

  // Row of cells, slot 0 is the head
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic              l_le;
      sfcpq_pkg::entry_t l_ent;
      sfcpq_pkg::entry_t r_ent;
      if (gi == 0) begin : g_first
        assign l_le  = 1'b1;
        assign l_ent = ctrl.ent;
      end else begin : g_mid
        assign l_le  = cell_le[gi-1];
        assign l_ent = cell_ent[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign r_ent = cell_ent[gi];
      end else begin : g_notlast
        assign r_ent = cell_ent[gi+1];
      end
      sfcpq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (CW'(gi) < cnt_r),
        .left_ent  (l_ent),
        .left_le   (l_le),
        .right_ent (r_ent),
        .ent       (cell_ent[gi]),
        .le        (cell_le[gi])
      );
    end
  endgenerate

  // Count and result
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = sfcpq_pkg::ST_ENQUEUED;
    head_nxt   = '0;
    if (in_opcode == sfcpq_pkg::OP_ENQ) begin
      if (full) begin
        status_nxt = sfcpq_pkg::ST_DROPPED;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = sfcpq_pkg::ST_EMPTY;
      end else begin
        status_nxt = sfcpq_pkg::ST_DEQUEUED;
        head_nxt   = cell_ent[0];
        cnt_nxt    = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= sfcpq_pkg::THRESH_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
    end
  end

  assign cnt_ext       = 32'(cnt_r);
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_tag       = head_r.tag;
  assign out_age       = head_r.age;
  assign out_condition = head_r.cond;
  assign out_occupancy = cnt_ext[sfcpq_pkg::OCC_W-1:0];

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("no result after accepted item");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == sfcpq_pkg::OP_ENQ && full)
      |=> (status_r == sfcpq_pkg::ST_DROPPED && $stable(cnt_r)))
    else $error("enqueue on full queue not dropped");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == sfcpq_pkg::OP_DEQ && !empty)
      |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("dequeue did not decrement count");

endmodule
